// ===== hdl/pbht_pkg.sv =====
// Shared types and constants for the polyline box hit test.
`default_nettype none
package pbht_pkg;

	localparam int COORD_W = 32;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture current vertex, test it
		logic face_start; // load pt1/pt2 for the selected face
		logic bis_step;   // one bisection step
		logic commit;     // store current vertex as previous
		logic [1:0] axis;
		logic side;
	} pbht_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cur_inside;
		logic prev_valid;
		logic face_ok;    // face has area and segment straddles its plane
		logic mid_inside;
	} pbht_sts_t;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic [2:0] REG_X_MIN = 3'd0;
	localparam logic [2:0] REG_X_MAX = 3'd1;
	localparam logic [2:0] REG_Y_MIN = 3'd2;
	localparam logic [2:0] REG_Y_MAX = 3'd3;
	localparam logic [2:0] REG_Z_MIN = 3'd4;
	localparam logic [2:0] REG_Z_MAX = 3'd5;

endpackage
`default_nettype wire

// ===== hdl/pbht_datapath.sv =====
// Datapath: box registers, previous vertex, bisection points and face tests.
`default_nettype none
module pbht_datapath
	import pbht_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic [2:0] cfg_idx,
	input  wire coord_t    cfg_data,
	output coord_t         cfg_rdata,
	input  wire logic [2:0] cfg_ridx,
	input  wire point_t    in_pt,
	input  wire logic      in_start,
	input  wire pbht_cmd_t cmd,
	output pbht_sts_t      sts
);

	coord_t lo_q [3];
	coord_t hi_q [3];
	point_t prev_q, cur_q, p1_q, p2_q;
	logic prev_valid_q, start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				lo_q[k] <= '0;
				hi_q[k] <= '0;
			end
			prev_q <= '0;
			prev_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_X_MIN: lo_q[0] <= cfg_data;
					REG_X_MAX: hi_q[0] <= cfg_data;
					REG_Y_MIN: lo_q[1] <= cfg_data;
					REG_Y_MAX: hi_q[1] <= cfg_data;
					REG_Z_MIN: lo_q[2] <= cfg_data;
					REG_Z_MAX: hi_q[2] <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.commit) begin
				prev_q <= cur_q;
				prev_valid_q <= 1'b1;
			end
		end
	end

	always_comb begin
		case (cfg_ridx)
			REG_X_MIN: cfg_rdata = lo_q[0];
			REG_X_MAX: cfg_rdata = hi_q[0];
			REG_Y_MIN: cfg_rdata = lo_q[1];
			REG_Y_MAX: cfg_rdata = hi_q[1];
			REG_Z_MIN: cfg_rdata = lo_q[2];
			REG_Z_MAX: cfg_rdata = hi_q[2];
			default:   cfg_rdata = '0;
		endcase
	end

	function automatic logic inside_f(point_t p, coord_t l0, coord_t h0, coord_t l1,
		coord_t h1, coord_t l2, coord_t h2);
		return (p.x >= l0) && (p.x <= h0) && (p.y >= l1) && (p.y <= h1)
			&& (p.z >= l2) && (p.z <= h2);
	endfunction

	// Signs are -1, 0, +1 relative to the plane; the product is <= 0 when
	// either is zero or they differ.
	function automatic logic meets_f(coord_t a, coord_t b, coord_t pl);
		logic agt, alt, bgt, blt;
		agt = a > pl;
		alt = a < pl;
		bgt = b > pl;
		blt = b < pl;
		return !((agt && bgt) || (alt && blt));
	endfunction

	function automatic coord_t half_f(coord_t a, coord_t b);
		logic signed [COORD_W:0] s;
		s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
		return s[COORD_W:1];
	endfunction

	function automatic coord_t pick_f(point_t p, logic [1:0] ax);
		case (ax)
			AXIS_X:  return p.x;
			AXIS_Y:  return p.y;
			default: return p.z;
		endcase
	endfunction

	point_t mid;
	coord_t plane, c1, c2, cm;
	logic area_ok;

	always_comb begin
		mid.x = half_f(p1_q.x, p2_q.x);
		mid.y = half_f(p1_q.y, p2_q.y);
		mid.z = half_f(p1_q.z, p2_q.z);
		case (cmd.axis)
			AXIS_X:  begin
				plane = cmd.side ? hi_q[0] : lo_q[0];
				area_ok = (hi_q[1] != lo_q[1]) && (hi_q[2] != lo_q[2]);
			end
			AXIS_Y:  begin
				plane = cmd.side ? hi_q[1] : lo_q[1];
				area_ok = (hi_q[2] != lo_q[2]) && (hi_q[0] != lo_q[0]);
			end
			default: begin
				plane = cmd.side ? hi_q[2] : lo_q[2];
				area_ok = (hi_q[0] != lo_q[0]) && (hi_q[1] != lo_q[1]);
			end
		endcase
		c1 = pick_f(p1_q, cmd.axis);
		c2 = pick_f(p2_q, cmd.axis);
		cm = pick_f(mid, cmd.axis);
		sts.cur_inside = inside_f(cur_q, lo_q[0], hi_q[0], lo_q[1], hi_q[1], lo_q[2],
			hi_q[2]);
		sts.mid_inside = inside_f(mid, lo_q[0], hi_q[0], lo_q[1], hi_q[1], lo_q[2],
			hi_q[2]);
		sts.prev_valid = prev_valid_q && !start_q;
		sts.face_ok = area_ok && meets_f(pick_f(prev_q, cmd.axis),
			pick_f(cur_q, cmd.axis), plane);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q <= in_pt;
			start_q <= in_start;
		end
		if (cmd.face_start) begin
			p1_q <= prev_q;
			p2_q <= cur_q;
		end else if (cmd.bis_step) begin
			if (meets_f(c1, cm, plane))
				p2_q <= mid;
			else if (meets_f(c2, cm, plane))
				p1_q <= mid;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/pbht_ctrl.sv =====
// Controller: sequences the vertex test, face tests and bisection steps.
`default_nettype none
module pbht_ctrl
	import pbht_pkg::*;
#(
	parameter int STEPS = 20
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	output logic      out_hit,
	output pbht_cmd_t cmd,
	input  wire pbht_sts_t sts
);

	localparam int CNT_W = $clog2(STEPS + 1);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_FACE  = 3'd2;
	localparam logic [2:0] ST_BIS   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [1:0] axis_q;
	logic side_q;
	logic [CNT_W-1:0] cnt_q;
	logic res_q, res_valid_q, hit_q;

	logic accept, deliver, last_face;
	assign in_stall  = (state_q != ST_IDLE) || res_valid_q;
	assign accept    = in_valid && !in_stall;
	assign out_valid = res_valid_q;
	assign out_hit   = hit_q;
	assign deliver   = res_valid_q && !out_stall;
	assign last_face = (axis_q == AXIS_Z) && side_q;

	always_comb begin
		cmd = '0;
		cmd.axis = axis_q;
		cmd.side = side_q;
		cmd.load = accept;
		cmd.face_start = (state_q == ST_FACE) && sts.face_ok;
		cmd.bis_step = (state_q == ST_BIS);
		cmd.commit = (state_q == ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q <= AXIS_X;
			side_q <= 1'b0;
			cnt_q <= '0;
			res_q <= 1'b0;
			res_valid_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			if (deliver)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					axis_q <= AXIS_X;
					side_q <= 1'b0;
					res_q <= sts.cur_inside;
					if (sts.cur_inside || !sts.prev_valid)
						state_q <= ST_DONE;
					else
						state_q <= ST_FACE;
				end
				ST_FACE: begin
					cnt_q <= '0;
					if (sts.face_ok)
						state_q <= ST_BIS;
					else if (last_face)
						state_q <= ST_DONE;
					else begin
						side_q <= !side_q;
						if (side_q)
							axis_q <= axis_q + 2'd1;
					end
				end
				ST_BIS: begin
					cnt_q <= cnt_q + 1'b1;
					if (sts.mid_inside) begin
						res_q <= 1'b1;
						state_q <= ST_DONE;
					end else if (cnt_q == CNT_W'(STEPS - 1)) begin
						if (last_face)
							state_q <= ST_DONE;
						else begin
							state_q <= ST_FACE;
							side_q <= !side_q;
							if (side_q)
								axis_q <= axis_q + 2'd1;
						end
					end
				end
				ST_DONE: begin
					hit_q <= res_q;
					res_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/polyline_box_hit_test.sv =====
// Top level of the polyline box hit test.
// One hit word per vertex: the vertex is tested against the box, then, unless
// it is inside or starts a line, each of the six faces that has area and whose
// plane the segment from the previous vertex straddles runs up to BISECT_STEPS
// bisection steps on one shared midpoint unit, one step a cycle, until a
// midpoint lies inside the box.
// The result waits in an output register; the next vertex is taken after it
// leaves. Box registers sit at byte addresses 0..20, four apart.
`default_nettype none
module polyline_box_hit_test
	import pbht_pkg::*;
#(
	parameter int BISECT_STEPS = 20
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic signed [31:0] point_x,
	input  wire logic signed [31:0] point_y,
	input  wire logic signed [31:0] point_z,
	input  wire logic        line_start,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             hit
);

	pbht_cmd_t cmd;
	pbht_sts_t sts;
	point_t in_pt;
	coord_t rdata;

	assign pready = 1'b1;
	assign in_pt.x = point_x;
	assign in_pt.y = point_y;
	assign in_pt.z = point_z;
	assign prdata = rdata;

	pbht_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (psel && penable && pwrite && (paddr[1:0] == 2'b00)),
		.cfg_idx  (paddr[4:2]),
		.cfg_data (pwdata),
		.cfg_rdata(rdata),
		.cfg_ridx (paddr[4:2]),
		.in_pt    (in_pt),
		.in_start (line_start),
		.cmd      (cmd),
		.sts      (sts)
	);

	pbht_ctrl #(.STEPS(BISECT_STEPS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_hit  (hit),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule
`default_nettype wire

// ===== bench/polyline_box_hit_test_test.sv =====
// Self-checking testbench for the polyline box hit test, with its own hit predictor.
`default_nettype none
module polyline_box_hit_test_test;
	import pbht_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   start;
	} vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
	logic line_start = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;

	polyline_box_hit_test uut (.*);

	always #6 clk = ~clk;

	// Predictor state.
	logic signed [33:0] lo [3];
	logic signed [33:0] hi [3];
	logic signed [33:0] last_pt [3];
	logic last_ok = 1'b0;

	vertex_t pending_words[$];
	logic    expected_hits[$];
	int errors = 0;
	int cycles = 0;
	int hold_off = 0;
	bit sender_pause = 1'b0;
	bit stim_done = 1'b0;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic bit in_box(input logic signed [33:0] p [3]);
		for (int k = 0; k < 3; k++)
			if (p[k] < lo[k] || p[k] > hi[k]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic int side_of(input logic signed [33:0] c, input logic signed [33:0] pl);
		return (c > pl) ? 1 : ((c < pl) ? -1 : 0);
	endfunction

	function automatic bit straddles(input logic signed [33:0] a, input logic signed [33:0] b,
			input logic signed [33:0] pl);
		return side_of(a, pl) * side_of(b, pl) <= 0;
	endfunction

	function automatic bit bisect_finds(input logic signed [33:0] a [3],
			input logic signed [33:0] b [3], input int ax, input logic signed [33:0] pl);
		logic signed [33:0] p1 [3];
		logic signed [33:0] p2 [3];
		logic signed [33:0] m [3];
		p1 = a;
		p2 = b;
		for (int i = 0; i < 20; i++) begin
			for (int k = 0; k < 3; k++) m[k] = (p1[k] + p2[k]) >>> 1;
			if (in_box(m)) return 1'b1;
			if (straddles(p1[ax], m[ax], pl)) p2 = m;
			else if (straddles(p2[ax], m[ax], pl)) p1 = m;
		end
		return 1'b0;
	endfunction

	function automatic bit predict_hit(input vertex_t v);
		logic signed [33:0] cur [3];
		bit h;
		int u, w;
		cur[0] = v.x;
		cur[1] = v.y;
		cur[2] = v.z;
		h = in_box(cur);
		if (!h && !v.start && last_ok) begin
			for (int ax = 0; ax < 3 && !h; ax++) begin
				u = (ax + 1) % 3;
				w = (ax + 2) % 3;
				if (hi[u] == lo[u] || hi[w] == lo[w]) continue;
				for (int s = 0; s < 2 && !h; s++) begin
					if (straddles(last_pt[ax], cur[ax], s ? hi[ax] : lo[ax]) &&
						bisect_finds(last_pt, cur, ax, s ? hi[ax] : lo[ax]))
						h = 1'b1;
				end
			end
		end
		last_pt = cur;
		last_ok = 1'b1;
		return h;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic signed [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx[2:1] != 2'd3) begin
			if (idx[0]) hi[idx[2:1]] = val;
			else lo[idx[2:1]] = val;
		end
	endtask

	task automatic set_box(input logic signed [31:0] b [6]);
		write_reg(REG_X_MIN, b[0]);
		write_reg(REG_X_MAX, b[1]);
		write_reg(REG_Y_MIN, b[2]);
		write_reg(REG_Y_MAX, b[3]);
		write_reg(REG_Z_MIN, b[4]);
		write_reg(REG_Z_MAX, b[5]);
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || in_valid || expected_hits.size() != 0)
			@(posedge clk);
		repeat (140) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rnd_coord(input int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 16'hFFFF)) - 32'sh8000;
			default: return ($signed($urandom_range(0, 16)) - 8) <<< 16;
		endcase
	endfunction

	task automatic add_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z, input logic s);
		vertex_t v;
		v.x = x;
		v.y = y;
		v.z = z;
		v.start = s;
		pending_words.push_back(v);
	endtask

	// Stall seen at the accepting edge.
	logic in_stall_q = 1'b0;
	always @(posedge clk) in_stall_q <= in_stall;

	// Driver.
	int gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall_q) begin
				expected_hits.push_back(predict_hit(pending_words.pop_front()));
				gap = $urandom_range(0, 3);
			end
			if (in_valid && in_stall_q) begin
			end else if (gap > 0) begin
				gap--;
				in_valid <= 1'b0;
			end else if (pending_words.size() != 0 && !sender_pause) begin
				in_valid <= 1'b1;
				point_x <= pending_words[0].x;
				point_y <= pending_words[0].y;
				point_z <= pending_words[0].z;
				line_start <= pending_words[0].start;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor and output stall.
	int rx_wait = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("polyline_box_hit_test_test: FAIL");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_hits.size() == 0)
				report("hit word with nothing expected");
			else if (hit !== expected_hits.pop_front())
				report($sformatf("hit=%b wrong at cycle %0d", hit, cycles));
		end
	end

	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off--;
			out_stall <= 1'b1;
		end else if (out_valid && !out_stall && rx_wait == 0) begin
			rx_wait = $urandom_range(0, 3);
			out_stall <= (rx_wait != 0);
		end else if (rx_wait > 0) begin
			rx_wait--;
			out_stall <= (rx_wait != 0);
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		logic signed [31:0] b [6];
		logic signed [31:0] one;
		int m;
		one = 32'sh10000;
		for (int k = 0; k < 3; k++) begin
			lo[k] = 0;
			hi[k] = 0;
			last_pt[k] = 0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Unit-ish box around the origin, with edge and crossing cases.
		b = '{-one, one, -one, one, -one, one};
		set_box(b);
		add_vertex(0, 0, 0, 1'b1);
		add_vertex(one, one, one, 1'b0);
		add_vertex(one + 1, 0, 0, 1'b0);
		add_vertex(-5 * one, 0, 0, 1'b1);
		add_vertex(5 * one, 0, 0, 1'b0);
		add_vertex(5 * one, 5 * one, 5 * one, 1'b0);
		add_vertex(-5 * one, -5 * one, -5 * one, 1'b0);
		add_vertex(-5 * one, 5 * one, 0, 1'b1);
		add_vertex(5 * one, 5 * one, 0, 1'b0);
		add_vertex(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
		add_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
		add_vertex(32'sh80000000, 32'sh7FFFFFFF, 0, 1'b0);
		add_vertex(0, 3 * one, 0, 1'b1);
		add_vertex(0, -3 * one, 0, 1'b0);
		add_vertex(0, 0, 3 * one, 1'b1);
		add_vertex(0, 0, -3 * one, 1'b0);
		wait_drained();

		// Inverted x range, then a flat box.
		b = '{one, -one, -one, one, -one, one};
		set_box(b);
		add_vertex(-3 * one, 0, 0, 1'b1);
		add_vertex(3 * one, 0, 0, 1'b0);
		add_vertex(0, 0, 0, 1'b0);
		wait_drained();
		b = '{-one, one, 0, 0, -one, one};
		set_box(b);
		add_vertex(0, -3 * one, 0, 1'b1);
		add_vertex(0, 3 * one, 0, 1'b0);
		add_vertex(0, 0, 0, 1'b0);
		wait_drained();

		// Long output hold-off: the block fills up and stalls its input.
		b = '{-2 * one, 2 * one, -one, 3 * one, -4 * one, one};
		set_box(b);
		hold_off = 600;
		for (int i = 0; i < 20; i++)
			add_vertex(rnd_coord(2), rnd_coord(2), rnd_coord(2), i % 5 == 0);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			if (phase == 3)
				b = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
					32'sh80000000, 32'sh7FFFFFFF};
			else
				for (int k = 0; k < 3; k++) begin
					b[2 * k] = rnd_coord(2);
					b[2 * k + 1] = b[2 * k] + $urandom_range(0, 6) * one;
				end
			set_box(b);
			m = (phase == 3) ? 0 : 2;
			for (int i = 0; i < 100; i++)
				add_vertex(rnd_coord(($urandom_range(0, 9) == 0) ? 0 : m),
					rnd_coord(($urandom_range(0, 9) == 0) ? 0 : m),
					rnd_coord(($urandom_range(0, 9) == 0) ? 0 : m),
					$urandom_range(0, 5) == 0);
			if (phase == 1) begin
				// Sender pause until everything has come back.
				while (pending_words.size() > 50) @(posedge clk);
				sender_pause = 1'b1;
				while (in_valid || expected_hits.size() != 0) @(posedge clk);
				sender_pause = 1'b0;
			end
			wait_drained();
		end

		if (errors == 0)
			$display("polyline_box_hit_test_test: PASS");
		else
			$display("polyline_box_hit_test_test: FAIL");
		$finish;
	end
endmodule
`default_nettype wire

// ===== polyline_box_hit_test.f =====
hdl/pbht_pkg.sv
hdl/pbht_datapath.sv
hdl/pbht_ctrl.sv
hdl/polyline_box_hit_test.sv
bench/polyline_box_hit_test_test.sv
